// ----- hdl/qpdh_pkg.sv -----
package qpdh_pkg;

  localparam int unsigned LOG2_SLOTS_DEF = 10;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CODE_W  = 21;
  localparam int unsigned KEY_W   = 3 * CODE_W;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // low bits of the hash product that can ever reach the slot number
  localparam int unsigned HASH_W     = 53;
  localparam int unsigned HASH_SHIFT = 33;

  localparam logic [63:0] FIB_MULT = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [31:0] FIB_LO   = FIB_MULT[31:0];
  localparam logic [20:0] FIB_HI   = FIB_MULT[52:32];

  localparam logic [HASH_W-1:0] ROUND_HALF = 53'h0_0000_8000_0000;
  localparam logic [CODE_W-1:0] CODE_BIAS  = 21'd8;

  localparam logic [31:0] INV_QUANTUM_RST = 32'h0001_0000;

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_QUANTUM = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [KEY_W-1:0] key;
  } slot_entry_t;

  // floor(p / 2^32 + 1/2) + 8, kept to the code width
  function automatic logic [CODE_W-1:0] quant_code(input logic [HASH_W-1:0] p);
    logic [HASH_W-1:0] t;
    t = p + ROUND_HALF;
    return t[HASH_W-1:32] + CODE_BIAS;
  endfunction

endpackage

// ----- hdl/qpdh_ram.sv -----
module qpdh_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/quantized_point_dedup_hash_core.sv -----
// Point deduplication table. A find item (in_op 0) quantizes the point against the
// configured origin and inverse quantum, packs the three 21-bit codes into a key and
// looks it up in a linear-probing hash table held in one synchronous RAM; a known key
// returns its stored index, a new key is inserted with the next sequential index and
// out_is_new set, and when no slot is free out_table_full is set and nothing changes.
// A clear item (in_op 1) empties the table and the point counter. A find keeps busy
// high while it quantizes, hashes and probes slots (one RAM read a cycle), and its
// result strobes on out_valid in the cycle busy drops; one shared 33x33 multiplier
// serves the three quantizations and the three partial products of the hash. A
// clear, and the clearing pass after reset, write every slot, one slot per cycle.
// Results appear for one cycle only: the receiver must take every out_valid strobe.
// Configure only while busy is low.
module quantized_point_dedup_hash_core #(
  parameter int unsigned LOG2_SLOTS = qpdh_pkg::LOG2_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [qpdh_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [qpdh_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [qpdh_pkg::COORD_W-1:0] in_coord_z,
  output logic                                out_valid,
  output logic [qpdh_pkg::IDX_W-1:0]          out_point_index,
  output logic                                out_is_new,
  output logic                                out_table_full,
  input  logic                                cfg_we,
  input  logic [qpdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qpdh_pkg::COORD_W-1:0]        cfg_data
);

  localparam int unsigned ENTRY_W = $bits(qpdh_pkg::slot_entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_QX, S_QY, S_QZ, S_QK, S_H0, S_H1, S_H2, S_H3, S_RD, S_CMP, S_CLR
  } state_t;

  state_t state_r, state_nxt;

  logic [qpdh_pkg::COORD_W-1:0] origin_x_r, origin_y_r, origin_z_r, inv_q_r;
  logic [qpdh_pkg::COORD_W-1:0] coord_x_r, coord_y_r, coord_z_r;
  logic [qpdh_pkg::COORD_W-1:0] coord_x_nxt, coord_y_nxt, coord_z_nxt;

  logic [qpdh_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [qpdh_pkg::HASH_W-1:0] acc_r, acc_nxt, hash_sum;
  logic signed [32:0]          mul_a, mul_b;
  logic signed [65:0]          prod_r;

  logic [LOG2_SLOTS-1:0] slot_r, slot_nxt, slot_inc;
  logic [LOG2_SLOTS-1:0] probes_r, probes_nxt;
  logic [qpdh_pkg::IDX_W-1:0] count_r, count_nxt;
  logic init_r, init_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [qpdh_pkg::IDX_W-1:0] out_index_r, out_index_nxt;
  logic                       out_new_r, out_new_nxt;
  logic                       out_full_r, out_full_nxt;

  logic                  ram_we;
  logic [LOG2_SLOTS-1:0] ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  qpdh_pkg::slot_entry_t rd_entry, wr_entry;

  logic signed [32:0] diff_x, diff_y, diff_z;

  assign diff_x = $signed({coord_x_r[31], coord_x_r}) - $signed({origin_x_r[31], origin_x_r});
  assign diff_y = $signed({coord_y_r[31], coord_y_r}) - $signed({origin_y_r[31], origin_y_r});
  assign diff_z = $signed({coord_z_r[31], coord_z_r}) - $signed({origin_z_r[31], origin_z_r});

  assign slot_inc = slot_r + {{(LOG2_SLOTS-1){1'b0}}, 1'b1};
  assign hash_sum = acc_r + {prod_r[20:0], 32'b0};
  assign rd_entry = ram_rdata;

  qpdh_ram #(
    .WIDTH  (ENTRY_W),
    .ADDR_W (LOG2_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    coord_x_nxt   = coord_x_r;
    coord_y_nxt   = coord_y_r;
    coord_z_nxt   = coord_z_r;
    key_nxt       = key_r;
    acc_nxt       = acc_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    count_nxt     = count_r;
    init_nxt      = init_r;
    out_valid_nxt = 1'b0;
    out_index_nxt = out_index_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    ram_we        = 1'b0;
    ram_raddr     = slot_r;
    wr_entry      = '0;
    mul_a         = '0;
    mul_b         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          coord_x_nxt = in_coord_x;
          coord_y_nxt = in_coord_y;
          coord_z_nxt = in_coord_z;
          if (in_op == qpdh_pkg::OP_CLEAR) begin
            slot_nxt  = '0;
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_QX;
          end
        end
      end
      S_QX: begin
        mul_a     = diff_x;
        mul_b     = {1'b0, inv_q_r};
        state_nxt = S_QY;
      end
      S_QY: begin
        mul_a = diff_y;
        mul_b = {1'b0, inv_q_r};
        key_nxt[3*qpdh_pkg::CODE_W-1 -: qpdh_pkg::CODE_W] =
          qpdh_pkg::quant_code(prod_r[qpdh_pkg::HASH_W-1:0]);
        state_nxt = S_QZ;
      end
      S_QZ: begin
        mul_a = diff_z;
        mul_b = {1'b0, inv_q_r};
        key_nxt[2*qpdh_pkg::CODE_W-1 -: qpdh_pkg::CODE_W] =
          qpdh_pkg::quant_code(prod_r[qpdh_pkg::HASH_W-1:0]);
        state_nxt = S_QK;
      end
      S_QK: begin
        key_nxt[qpdh_pkg::CODE_W-1:0] = qpdh_pkg::quant_code(prod_r[qpdh_pkg::HASH_W-1:0]);
        state_nxt = S_H0;
      end
      // key * fib mod 2^53 = lo*lo + (lo*hi + hi*lo) << 32
      S_H0: begin
        mul_a     = {1'b0, key_r[31:0]};
        mul_b     = {1'b0, qpdh_pkg::FIB_LO};
        state_nxt = S_H1;
      end
      S_H1: begin
        mul_a     = {1'b0, key_r[31:0]};
        mul_b     = {12'b0, qpdh_pkg::FIB_HI};
        acc_nxt   = prod_r[qpdh_pkg::HASH_W-1:0];
        state_nxt = S_H2;
      end
      S_H2: begin
        mul_a     = {12'b0, key_r[52:32]};
        mul_b     = {1'b0, qpdh_pkg::FIB_LO};
        acc_nxt   = hash_sum;
        state_nxt = S_H3;
      end
      S_H3: begin
        slot_nxt   = hash_sum[qpdh_pkg::HASH_SHIFT +: LOG2_SLOTS];
        probes_nxt = '0;
        state_nxt  = S_RD;
      end
      S_RD: begin
        ram_raddr = slot_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!rd_entry.valid) begin
          ram_we         = 1'b1;
          wr_entry.valid = 1'b1;
          wr_entry.index = count_r;
          wr_entry.key   = key_r;
          count_nxt      = count_r + {{(qpdh_pkg::IDX_W-1){1'b0}}, 1'b1};
          out_valid_nxt  = 1'b1;
          out_index_nxt  = count_r;
          out_new_nxt    = 1'b1;
          out_full_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end else if (rd_entry.key == key_r) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = rd_entry.index;
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end else if (probes_r == '1) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = '0;
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // next probe read issued from here, one slot per cycle
          ram_raddr  = slot_inc;
          slot_nxt   = slot_inc;
          probes_nxt = probes_r + {{(LOG2_SLOTS-1){1'b0}}, 1'b1};
        end
      end
      S_CLR: begin
        ram_we   = 1'b1;
        slot_nxt = slot_inc;
        if (slot_r == '1) begin
          count_nxt = '0;
          init_nxt  = 1'b0;
          state_nxt = S_IDLE;
          // the pass after reset gives no result
          if (!init_r) begin
            out_valid_nxt = 1'b1;
            out_index_nxt = '0;
            out_new_nxt   = 1'b0;
            out_full_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_a * mul_b;
    coord_x_r <= coord_x_nxt;
    coord_y_r <= coord_y_nxt;
    coord_z_r <= coord_z_nxt;
    key_r     <= key_nxt;
    acc_r     <= acc_nxt;
    probes_r  <= probes_nxt;
    if (!rst_n) begin
      state_r     <= S_CLR;
      slot_r      <= '0;
      count_r     <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      out_index_r <= '0;
      out_new_r   <= 1'b0;
      out_full_r  <= 1'b0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      origin_z_r  <= '0;
      inv_q_r     <= qpdh_pkg::INV_QUANTUM_RST;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      out_index_r <= out_index_nxt;
      out_new_r   <= out_new_nxt;
      out_full_r  <= out_full_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          qpdh_pkg::REG_ORIGIN_X:    origin_x_r <= cfg_data;
          qpdh_pkg::REG_ORIGIN_Y:    origin_y_r <= cfg_data;
          qpdh_pkg::REG_ORIGIN_Z:    origin_z_r <= cfg_data;
          qpdh_pkg::REG_INV_QUANTUM: inv_q_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_index = out_index_r;
  assign out_is_new      = out_new_r;
  assign out_table_full  = out_full_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while still working");

  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_full_r))
    else $error("result both new and full");

  a_full_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (out_index_r == '0))
    else $error("full result carries an index");

  a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CMP || state_r == S_CLR))
    else $error("slot ram written outside insert or clear");

  a_probe_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (probes_r == '0))
    else $error("probe count not cleared at lookup start");

endmodule
